[rtl/tape_fsk_modem_tick_core_macros.svh]
// ----------------------------------------------------------------------------
// tape_fsk_modem_tick_core_macros.svh
// Assertion helpers for the cassette modem RTL
// ----------------------------------------------------------------------------
`ifndef TAPE_FSK_MODEM_TICK_CORE_MACROS_SVH
`define TAPE_FSK_MODEM_TICK_CORE_MACROS_SVH

// implication check on clk_i, masked while rst_ni is low
`define TFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen on clk_i
`define TFM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/tfm_pkg.sv]
// ----------------------------------------------------------------------------
// tfm_pkg
// Types and constants for the cassette FSK modem tick core
// ----------------------------------------------------------------------------
package tfm_pkg;

  // serial_mode codes; bit 1 set means serial port, tape idle
  typedef enum logic [1:0] {
    MODE_TAPE_300  = 2'd0,
    MODE_TAPE_1200 = 2'd1,
    MODE_SERIAL_A  = 2'd2,
    MODE_SERIAL_B  = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic {
    REG_SERIAL_MODE = 1'b0,
    REG_THRESHOLD   = 1'b1
  } reg_idx_e;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned InDataWidth  = 24;
  localparam int unsigned OutDataWidth = 8;

  localparam logic signed [15:0] ThresholdReset = 16'sd655;

  // decoder period limits, in ticks
  localparam int unsigned Short300  = 6;
  localparam int unsigned Short1200 = 10;
  localparam int unsigned LongLimit = 32;

  // encoder masks (5-bit tick counter)
  localparam logic [4:0] PeriodMask300  = 5'h1f;
  localparam logic [4:0] PeriodMask1200 = 5'h07;
  localparam logic [4:0] HalfMask300    = 5'h03;
  localparam logic [4:0] HalfMask1200   = 5'h07;
  localparam logic [4:0] SkipBit300     = 5'h04;
  localparam logic [4:0] SkipBit1200    = 5'h08;

  typedef struct packed {
    logic adv;     // item leaves the input register this cycle
    logic active;  // tape mode, state may change
    logic fast;    // 1200 baud
  } tick_ctrl_t;

  typedef struct packed {
    logic bit_val;
    logic valid;
  } rx_res_t;

  typedef struct packed {
    logic level;
    logic valid;
  } tx_res_t;

endpackage

[rtl/tape_fsk_modem_tick_core.sv]
// ----------------------------------------------------------------------------
// tape_fsk_modem_tick_core
// Cassette FSK modem, one beat per 19200 Hz tick
//
//   channel   dir  beat contents (tdata, low bit first)
//   s_axis    in   tape_sample[15:0], uart_serial_out[16], zero pad
//   m_axis    out  rx_bit, rx_bit_valid, tape_drive_level, tape_drive_valid
//   cfg       in   0: serial_mode, 1: sample_threshold
//
// One beat per cycle while m_axis accepts, via the input register, then the
// result register. Decoder and encoder state advance as a beat moves
// from the input register into the result register. Reset: decoder count 0,
// level 0, bit 1; encoder count 0, bit 0, drive level 1. A stall on m_axis
// fills the result register, then the input register, then drops tready.
// ----------------------------------------------------------------------------
module tape_fsk_modem_tick_core #(
  parameter int unsigned IN_COUNT_WIDTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] tape_sample, [16] uart_serial_out, [23:17] zero
  input  logic [tfm_pkg::InDataWidth-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] rx_bit, [1] rx_bit_valid, [2] tape_drive_level, [3] tape_drive_valid
  output logic [tfm_pkg::OutDataWidth-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [tfm_pkg::CfgDataWidth-1:0]    cfg_data_i
);
  import tfm_pkg::*;
  `include "tape_fsk_modem_tick_core_macros.svh"

  logic               serial_port; // serial port modes, tape idle
  logic [1:0]         serial_mode_q;
  logic signed [15:0] threshold_q;

  logic               in_valid_q;
  logic [16:0]        in_data_q;
  logic               out_valid_q;
  logic [3:0]         out_data_q;
  logic               adv;
  tick_ctrl_t         ctrl;
  rx_res_t            rx;
  tx_res_t            tx;

  assign serial_port = serial_mode_q[1];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_mode_q <= MODE_TAPE_300;
      threshold_q   <= ThresholdReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SERIAL_MODE: serial_mode_q <= cfg_data_i[1:0];
        REG_THRESHOLD:   threshold_q   <= signed'(cfg_data_i);
        default:         ;
      endcase
    end
  end

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  assign ctrl.adv    = adv;
  assign ctrl.active = !serial_port;
  assign ctrl.fast   = (serial_mode_q == MODE_TAPE_1200);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[16:0];
    end
  end

  tfm_rx_dec #(
    .CntWidth (IN_COUNT_WIDTH)
  ) u_rx_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sample_i    (signed'(in_data_q[15:0])),
    .threshold_i (threshold_q),
    .rx_o        (rx)
  );

  tfm_tx_enc u_tx_enc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .uart_i (in_data_q[16]),
    .tx_o   (tx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {tx.valid, tx.level, rx.valid, rx.bit_val};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth-4){1'b0}}, out_data_q};

  `TFM_ASSERT(a_adv_fills_out, adv |=> out_valid_q, "result register missed a beat")
  `TFM_ASSERT(a_in_hold, in_valid_q && !adv |=> in_valid_q && $stable(in_data_q),
    "input register lost a stalled beat")
  `TFM_ASSERT(a_serial_idle, adv && serial_port |=> !out_data_q[1] && !out_data_q[3],
    "update flagged in serial port mode")
  `TFM_ASSERT_NEVER(a_no_ready_when_full, s_axis_tready && in_valid_q && !adv,
    "tready high with a stalled input register")

endmodule

[rtl/tfm_rx_dec.sv]
// ----------------------------------------------------------------------------
// tfm_rx_dec
// Tape input decoder: level slicer and period counter
// ----------------------------------------------------------------------------
module tfm_rx_dec #(
  parameter int unsigned CntWidth = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfm_pkg::tick_ctrl_t ctrl_i,
  input  logic signed [15:0] sample_i,
  input  logic signed [15:0] threshold_i,
  output tfm_pkg::rx_res_t   rx_o
);
  import tfm_pkg::*;

  localparam logic [CntWidth-1:0] CntMax  = {CntWidth{1'b1}};
  localparam logic [CntWidth-1:0] CntS300 = CntWidth'(Short300);
  localparam logic [CntWidth-1:0] CntS1200 = CntWidth'(Short1200);
  localparam logic [CntWidth-1:0] CntLong = CntWidth'(LongLimit);

  logic [CntWidth-1:0] cnt_q, cnt_d, cnt_inc;
  logic                level_q, level_d;
  logic                bit_q, bit_d;
  logic                lvl, changed, hit, bit_new, valid;

  always_comb begin
    lvl     = (sample_i > threshold_i);
    changed = (lvl != level_q);
    cnt_inc = (cnt_q != CntMax) ? cnt_q + 1'b1 : cnt_q;
    hit     = changed || (ctrl_i.fast && (cnt_inc == CntS1200));
    bit_new = ctrl_i.fast ? (cnt_inc < CntS1200 || cnt_inc > CntLong)
                          : (cnt_inc < CntS300  || cnt_inc > CntLong);
    valid   = ctrl_i.active && hit;

    cnt_d   = cnt_q;
    level_d = level_q;
    bit_d   = bit_q;
    if (ctrl_i.active) begin
      cnt_d = changed ? '0 : cnt_inc;
      level_d = lvl;
      if (hit) begin
        bit_d = bit_new;
      end
    end
  end

  assign rx_o.bit_val = bit_d;
  assign rx_o.valid   = valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      level_q <= 1'b0;
      bit_q   <= 1'b1;
    end else if (ctrl_i.adv) begin
      cnt_q   <= cnt_d;
      level_q <= level_d;
      bit_q   <= bit_d;
    end
  end

endmodule

[rtl/tfm_tx_enc.sv]
// ----------------------------------------------------------------------------
// tfm_tx_enc
// Tape output encoder: UART bit sampler and FSK toggle generator
// ----------------------------------------------------------------------------
module tfm_tx_enc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfm_pkg::tick_ctrl_t ctrl_i,
  input  logic                uart_i,
  output tfm_pkg::tx_res_t    tx_o
);
  import tfm_pkg::*;

  logic [4:0] cnt_q, cnt_d, cnt_inc, period_mask, half_mask, skip_bit;
  logic       bit_q, bit_d, level_q, level_d, toggle;

  always_comb begin
    period_mask = ctrl_i.fast ? PeriodMask1200 : PeriodMask300;
    half_mask   = ctrl_i.fast ? HalfMask1200   : HalfMask300;
    skip_bit    = ctrl_i.fast ? SkipBit1200    : SkipBit300;
    cnt_inc     = cnt_q + 5'd1;

    cnt_d = cnt_q;
    bit_d = bit_q;
    toggle = 1'b0;
    if (ctrl_i.active) begin
      cnt_d = cnt_inc;
      // resync the bit cell on a new UART bit at a period boundary
      if ((cnt_inc & period_mask) == '0 && uart_i != bit_q) begin
        bit_d = uart_i;
        cnt_d = '0;
      end
      // a zero bit drops every other toggle
      toggle = ((cnt_d & half_mask) == '0) &&
               !(!bit_d && (cnt_d & skip_bit) != '0);
    end
    level_d = level_q ^ toggle;
  end

  assign tx_o.level = level_d;
  assign tx_o.valid = toggle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      bit_q   <= 1'b0;
      level_q <= 1'b1;
    end else if (ctrl_i.adv) begin
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      level_q <= level_d;
    end
  end

endmodule

[sim/tape_fsk_modem_tick_core_checker.sv]
// ----------------------------------------------------------------------------
// tape_fsk_modem_tick_core_checker
// Watches the tick streams of the cassette modem and checks every result beat
//
// Keeps its own copy of the decoder and encoder state and of the two
// configuration registers. Each accepted input beat advances that copy and
// queues the expected result. Each result beat is compared field by field
// with the oldest queued result.
// ----------------------------------------------------------------------------
module tape_fsk_modem_tick_core_checker #(
  parameter int unsigned IN_COUNT_WIDTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [tfm_pkg::InDataWidth-1:0]  s_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [tfm_pkg::OutDataWidth-1:0] m_tdata_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [tfm_pkg::CfgDataWidth-1:0] cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  // same order as the low nibble of m_axis_tdata
  typedef struct packed {
    logic drive_valid;
    logic drive_level;
    logic rx_valid;
    logic rx_bit;
  } tick_res_t;

  localparam logic [IN_COUNT_WIDTH-1:0] GapMax = '1;

  tfm_pkg::mode_e           mode_q;
  logic signed [15:0]       thr_q;

  logic [IN_COUNT_WIDTH-1:0] gap_q;
  logic                      line_level_q;
  logic                      rx_bit_q;
  logic [4:0]                enc_ticks_q;
  logic                      enc_bit_q;
  logic                      drive_q;

  tick_res_t tick_results[$];
  int        fails;

  task automatic advance_modem(input logic signed [15:0] smp, input logic uart,
                               output tick_res_t res);
    logic       lvl;
    logic       fast;
    logic       flip;
    logic [4:0] pmask;
    logic [4:0] hmask;
    logic [4:0] skip;
    res = '0;
    if (!mode_q[1]) begin
      fast  = (mode_q == tfm_pkg::MODE_TAPE_1200);
      lvl   = (smp > thr_q);
      pmask = fast ? tfm_pkg::PeriodMask1200 : tfm_pkg::PeriodMask300;
      hmask = fast ? tfm_pkg::HalfMask1200 : tfm_pkg::HalfMask300;
      skip  = fast ? tfm_pkg::SkipBit1200 : tfm_pkg::SkipBit300;
      flip  = (lvl != line_level_q);

      if (gap_q != GapMax) gap_q = gap_q + 1'b1;
      if (!fast) begin
        if (flip) begin
          line_level_q = lvl;
          rx_bit_q     = (gap_q < tfm_pkg::Short300) || (gap_q > tfm_pkg::LongLimit);
          gap_q        = '0;
          res.rx_valid = 1'b1;
        end
      end else if (flip || gap_q == tfm_pkg::Short1200) begin
        // at 1200 baud a bit also falls out when the count hits 10
        rx_bit_q = (gap_q < tfm_pkg::Short1200) || (gap_q > tfm_pkg::LongLimit);
        if (flip) begin
          gap_q        = '0;
          line_level_q = lvl;
        end
        res.rx_valid = 1'b1;
      end

      enc_ticks_q = enc_ticks_q + 5'd1;
      if ((enc_ticks_q & pmask) == 5'd0 && uart != enc_bit_q) begin
        enc_bit_q   = uart;
        enc_ticks_q = 5'd0;
      end
      // a zero bit skips every other toggle
      if ((enc_ticks_q & hmask) == 5'd0 && !(!enc_bit_q && (enc_ticks_q & skip) != 5'd0)) begin
        drive_q         = ~drive_q;
        res.drive_valid = 1'b1;
      end
    end
    res.rx_bit      = rx_bit_q;
    res.drive_level = drive_q;
  endtask

  function automatic int field_differs(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_res_t want;
    tick_res_t got;
    if (!rst_ni) begin
      mode_q       = tfm_pkg::MODE_TAPE_300;
      thr_q        = tfm_pkg::ThresholdReset;
      gap_q        = '0;
      line_level_q = 1'b0;
      rx_bit_q     = 1'b1;
      enc_ticks_q  = 5'd0;
      enc_bit_q    = 1'b0;
      drive_q      = 1'b1;
      tick_results.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == tfm_pkg::REG_SERIAL_MODE) mode_q = tfm_pkg::mode_e'(cfg_data_i[1:0]);
        else thr_q = cfg_data_i;
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[3:0];
        if (tick_results.size() == 0) begin
          $error("result beat %h with nothing expected", m_tdata_i);
          fails++;
        end else begin
          want = tick_results.pop_front();
          fails += field_differs("rx_bit", want.rx_bit, got.rx_bit);
          fails += field_differs("rx_bit_valid", want.rx_valid, got.rx_valid);
          fails += field_differs("tape_drive_level", want.drive_level, got.drive_level);
          fails += field_differs("tape_drive_valid", want.drive_valid, got.drive_valid);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        advance_modem(s_tdata_i[15:0], s_tdata_i[16], want);
        tick_results.push_back(want);
      end
      fail_count_o <= fails;
      pending_o    <= tick_results.size();
    end
  end

endmodule

[sim/tape_fsk_modem_tick_core_test.sv]
// ----------------------------------------------------------------------------
// tape_fsk_modem_tick_core_test
// Stimulus and verdict for the cassette FSK modem tick core
//
// A short directed run at reset settings, then segments of square-wave tape
// input and UART bit streams under several modes and thresholds, six of nine
// with random idling on both streams. The checker does all the comparing.
// ----------------------------------------------------------------------------
module tape_fsk_modem_tick_core_test;

  localparam int unsigned CountWidth = 8;
  localparam int SegTicks = 215;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [tfm_pkg::InDataWidth-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [tfm_pkg::OutDataWidth-1:0] m_axis_tdata;
  logic                             cfg_we_i = 1'b0;
  logic                             cfg_idx_i = tfm_pkg::REG_SERIAL_MODE;
  logic [tfm_pkg::CfgDataWidth-1:0] cfg_data_i = '0;

  int fail_count;
  int pending;
  int src_idle_pct = 11;
  int sink_idle_pct = 80;
  int thr_now = 655;

  always #5 clk_i = ~clk_i;

  tape_fsk_modem_tick_core #(.IN_COUNT_WIDTH(CountWidth)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  tape_fsk_modem_tick_core_checker #(.IN_COUNT_WIDTH(CountWidth)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_tick(input logic [15:0] smp, input logic uart);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(tfm_pkg::InDataWidth - 17){1'b0}}, uart, smp};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and let every queued result come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input int mode, input int thr);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tfm_pkg::REG_SERIAL_MODE;
    // upper bits of the mode write are don't-care
    cfg_data_i <= {14'($urandom_range(16'h3fff)), 2'(mode)};
    @(negedge clk_i);
    cfg_idx_i  <= tfm_pkg::REG_THRESHOLD;
    cfg_data_i <= 16'(thr);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    thr_now = thr;
  endtask

  function automatic logic [15:0] high_sample(int thr);
    if (thr >= 32767) return 16'h7fff;  // nothing reads high here
    if ($urandom_range(3) == 0) return 16'(thr + 1);
    return 16'(int'($urandom_range(32766 - thr)) + thr + 1);
  endfunction

  function automatic logic [15:0] low_sample(int thr);
    if ($urandom_range(3) == 0) return 16'(thr);
    return 16'(int'($urandom_range(thr + 32768)) - 32768);
  endfunction

  task automatic run_ticks(input int count, input int bit_ticks);
    int          tape_left;
    int          uart_left;
    int          pick;
    logic        tape_hi;
    logic        uart_b;
    logic [15:0] smp;
    tape_left = 0;
    uart_left = 0;
    tape_hi   = 1'($urandom_range(1));
    uart_b    = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (tape_left <= 0) begin
        tape_hi = ~tape_hi;
        pick    = $urandom_range(99);
        if (pick < 4) tape_left = $urandom_range(250, 300);  // long run, may saturate the gap count
        else if (pick < 16) tape_left = 1;                   // glitch
        else tape_left = $urandom_range(2, 40);
      end
      if (uart_left <= 0) begin
        uart_b    = 1'($urandom_range(1));
        uart_left = ($urandom_range(9) == 0) ? $urandom_range(1, 40)
                                             : bit_ticks * $urandom_range(1, 4);
      end
      smp = tape_hi ? high_sample(thr_now) : low_sample(thr_now);
      if ($urandom_range(19) == 0) smp = 16'($urandom);
      send_tick(smp, uart_b);
      tape_left--;
      uart_left--;
    end
  endtask

  initial begin
    logic [15:0] dir_smp[22] = '{16'h8000, 16'h7fff, 16'd656, 16'd655, 16'd0, 16'hffff,
                                 16'h8000, -16'sd200, -16'sd5, 16'd1000, 16'd20000,
                                 -16'sd20000, 16'h7fff, 16'h8000, 16'd655, 16'd656,
                                 16'd0, 16'h7fff, 16'hffff, 16'd12345, -16'sd12345,
                                 16'd654};
    logic        dir_uart[22] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                  1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                                  1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    int seg_mode[9] = '{0, 1, 2, 1, 0, 3, 1, 0, 1};
    int seg_thr[9]  = '{655, 0, -32768, 32767, -32768, 0, 0, 0, 655};
    int thr;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: threshold edges, full-scale samples, short and
    // exactly-six-tick periods
    for (int i = 0; i < 22; i++) send_tick(dir_smp[i], dir_uart[i]);

    for (int seg = 0; seg < 9; seg++) begin
      drain();
      case (seg / 3)
        0: begin
          src_idle_pct  = 11;
          sink_idle_pct = 80;
        end
        1: begin
          src_idle_pct  = 80;
          sink_idle_pct = 11;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      thr = (seg >= 5 && seg <= 7) ? int'($urandom_range(65535)) - 32768 : seg_thr[seg];
      write_regs(seg_mode[seg], thr);
      run_ticks(SegTicks, (seg_mode[seg] == tfm_pkg::MODE_TAPE_1200) ? 8 : 32);
    end

    drain();
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
